// ===== src/glse_pkg.sv =====
// ----------------------------------------------------------------------------
// glse_pkg
// Shared constants, types and helper functions of the literal LZW encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package glse_pkg;

   localparam int CodeBits    = 9;
   localparam int MaxBlock    = 255;
   localparam int QueueDepth  = 2;
   localparam int PixelCountW = 25;
   localparam int PayloadW    = 26;
   localparam int CsrIndexW   = 1;
   localparam int CsrDataW    = 25;
   localparam int ReqDataW    = 40;
   // leftover bits (at most 7) plus clear, index and end codes
   localparam int SrW         = 7 + 3 * CodeBits;

   localparam logic [CodeBits-1:0]    ClearCode = 9'd256;
   localparam logic [CodeBits-1:0]    EndCode   = 9'd257;
   localparam logic [PixelCountW-1:0] MaxPixels = 25'h100_0000;

   localparam logic [CsrIndexW-1:0] RegExactMode  = 1'b0;
   localparam logic [CsrIndexW-1:0] RegPixelCount = 1'b1;

   typedef struct packed {
      logic [7:0] index;
      logic       last;
   } glse_entry_type;

   // x / 255 for x below 2040
   function automatic logic [2:0] div255(input logic [10:0] x);
      logic [11:0] s;
      s = {1'b0, x} + 12'(x >> 8) + 12'd1;
      return s[10:8];
   endfunction

   // 3-3-2 quantization, raised to at least 1
   function automatic logic [7:0] quantize(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
      logic [10:0] r7;
      logic [10:0] g7;
      logic [10:0] b3;
      logic [2:0]  qb;
      logic [7:0]  idx;
      r7  = ({3'b0, r} << 3) - {3'b0, r};
      g7  = ({3'b0, g} << 3) - {3'b0, g};
      b3  = ({3'b0, b} << 1) + {3'b0, b};
      qb  = div255(b3);
      idx = {div255(r7), div255(g7), qb[1:0]};
      return (idx == 8'd0) ? 8'd1 : idx;
   endfunction

   // (min(count, 2^24) * 18 + 16) / 8
   function automatic logic [PayloadW-1:0] payload_bytes(input logic [PixelCountW-1:0] count);
      logic [PixelCountW-1:0] c;
      logic [29:0]            p;
      c = (count > MaxPixels) ? MaxPixels : count;
      p = ({5'b0, c} << 4) + ({5'b0, c} << 1) + 30'd16;
      return p[28:3];
   endfunction

endpackage

`default_nettype wire

// ===== src/glse_front.sv =====
// ----------------------------------------------------------------------------
// glse_front
// Accepts pixel words and maps each pixel to its palette index.
// ----------------------------------------------------------------------------
`default_nettype none

module glse_front (
   input  wire logic                          exact_mode,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [glse_pkg::ReqDataW-1:0] req_tdata,
   input  wire logic                          req_tlast,
   input  wire logic                          q_full,
   output logic                               q_push,
   output glse_pkg::glse_entry_type           q_entry
);

   logic [7:0] alpha;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [7:0] xidx;

   assign alpha = req_tdata[7:0];
   assign red   = req_tdata[15:8];
   assign green = req_tdata[23:16];
   assign blue  = req_tdata[31:24];
   assign xidx  = req_tdata[39:32];

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   always_comb begin
      priority if (alpha == 8'd0) begin
         q_entry.index = 8'd0;
      end else if (exact_mode) begin
         q_entry.index = xidx;
      end else begin
         q_entry.index = glse_pkg::quantize(red, green, blue);
      end
      q_entry.last = req_tlast;
   end

endmodule

`default_nettype wire

// ===== src/glse_queue.sv =====
// ----------------------------------------------------------------------------
// glse_queue
// Short FIFO of classified pixels between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module glse_queue #(
   parameter int DEPTH = glse_pkg::QueueDepth
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  glse_pkg::glse_entry_type      push_entry,
   output logic                          full,
   input  wire logic                     pop,
   output logic                          valid,
   output glse_pkg::glse_entry_type      head
);

   localparam int PtrW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);

   glse_pkg::glse_entry_type store_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff;
   logic [PtrW-1:0] rd_ptr_ff;
   logic [CntW-1:0] count_ff;
   logic            do_push;
   logic            do_pop;

   assign full    = (count_ff == CntW'(DEPTH));
   assign valid   = (count_ff != '0);
   assign head    = store_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CntW'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CntW'(1);
         end
      end
   end

endmodule

`default_nettype wire

// ===== src/glse_back.sv =====
// ----------------------------------------------------------------------------
// glse_back
// Packs codes into bytes, inserts sub-block lengths and the terminator,
// one output word per cycle through an output register unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module glse_back (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic [glse_pkg::PixelCountW-1:0] pixel_count,
   input  wire logic                             q_valid,
   input  glse_pkg::glse_entry_type              q_head,
   output logic                                  q_pop,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [7:0]                            rsp_tdata,
   output logic                                  rsp_tlast,
   output logic                                  rsp_tuser
);

   localparam int SrW = glse_pkg::SrW;
   localparam int PlW = glse_pkg::PayloadW;

   typedef enum logic [2:0] {
      ActIdle,
      ActDrop,
      ActLen,
      ActData,
      ActTerm
   } glse_action_type;

   logic [SrW-1:0] sr_ff,        sr_in,        sr_step;
   logic [2:0]     cnt_ff,       cnt_in,       cnt_step;
   logic [2:0]     data_left_ff, data_left_in, data_left_step;
   logic           term_ff,      term_in,      term_step;
   logic           open_ff,      open_in,      open_step;
   logic [PlW-1:0] payload_ff,   payload_in,   payload_step;
   logic [7:0]     block_ff,     block_in,     block_step;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     rsp_data_ff,  rsp_data_in;
   logic           rsp_last_ff,  rsp_last_in;
   logic           rsp_user_ff,  rsp_user_in;

   glse_action_type kind;
   logic           out_free;
   logic           fire;
   logic           run_end;
   logic           emit;
   logic [7:0]     emit_byte;
   logic           emit_last;
   logic           emit_done;
   logic           load;
   logic [2:0]     c0;
   logic [SrW-1:0] mask;
   logic [SrW-1:0] base;
   logic [SrW-1:0] bits;
   logic [5:0]     total;
   logic [5:0]     total_up;
   logic [2:0]     nb;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

   always_comb begin
      priority if (data_left_ff != 3'd0) begin
         priority if (payload_ff == '0) begin
            kind = ActDrop;
         end else if (block_ff == 8'd0) begin
            kind = ActLen;
         end else begin
            kind = ActData;
         end
      end else if (term_ff) begin
         kind = ActTerm;
      end else begin
         kind = ActIdle;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign fire     = (kind == ActDrop) || ((kind != ActIdle) && out_free);

   // one step of the current run
   always_comb begin
      sr_step        = sr_ff;
      cnt_step       = cnt_ff;
      data_left_step = data_left_ff;
      term_step      = term_ff;
      open_step      = open_ff;
      payload_step   = payload_ff;
      block_step     = block_ff;
      emit           = 1'b0;
      emit_byte      = 8'd0;
      emit_last      = 1'b0;
      emit_done      = 1'b0;
      run_end        = 1'b0;
      if (fire) begin
         unique case (kind)
            ActDrop: begin
               data_left_step = 3'd0;
               run_end        = !term_ff;
            end
            ActLen: begin
               emit       = 1'b1;
               emit_byte  = (payload_ff < PlW'(glse_pkg::MaxBlock)) ? payload_ff[7:0]
                                                                   : 8'(glse_pkg::MaxBlock);
               block_step = emit_byte;
            end
            ActData: begin
               emit           = 1'b1;
               emit_byte      = sr_ff[7:0];
               emit_last      = ((data_left_ff == 3'd1) || (payload_ff == PlW'(1))) && !term_ff;
               sr_step        = sr_ff >> 8;
               data_left_step = data_left_ff - 3'd1;
               payload_step   = payload_ff - PlW'(1);
               block_step     = block_ff - 8'd1;
               run_end        = (data_left_ff == 3'd1) && !term_ff;
            end
            ActTerm: begin
               emit         = 1'b1;
               emit_byte    = 8'd0;
               emit_last    = 1'b1;
               emit_done    = 1'b1;
               term_step    = 1'b0;
               open_step    = 1'b0;
               payload_step = '0;
               block_step   = 8'd0;
               cnt_step     = 3'd0;
               sr_step      = '0;
               run_end      = 1'b1;
            end
            ActIdle: begin
            end
            default: begin
            end
         endcase
      end
   end

   // next pixel: append clear, index and (on the last pixel) end codes
   assign load = q_valid && ((kind == ActIdle) || run_end);
   assign q_pop = load;

   always_comb begin
      c0       = open_step ? cnt_step : 3'd0;
      mask     = (SrW'(1) << cnt_step) - SrW'(1);
      base     = open_step ? (sr_step & mask) : '0;
      bits     = base
               | (SrW'(glse_pkg::ClearCode) << c0)
               | (SrW'(q_head.index) << ({3'b0, c0} + 6'(glse_pkg::CodeBits)))
               | (q_head.last ? (SrW'(glse_pkg::EndCode)
                                 << ({3'b0, c0} + 6'(2 * glse_pkg::CodeBits))) : '0);
      total    = {3'b0, c0} + 6'(2 * glse_pkg::CodeBits)
               + (q_head.last ? 6'(glse_pkg::CodeBits) : 6'd0);
      total_up = total + 6'd7;
      nb       = q_head.last ? total_up[5:3] : total[5:3];
   end

   always_comb begin
      sr_in        = sr_step;
      cnt_in       = cnt_step;
      data_left_in = data_left_step;
      term_in      = term_step;
      open_in      = open_step;
      payload_in   = payload_step;
      block_in     = block_step;
      if (load) begin
         sr_in        = bits;
         cnt_in       = q_head.last ? 3'd0 : total[2:0];
         data_left_in = nb;
         term_in      = q_head.last;
         open_in      = 1'b1;
         if (!open_step) begin
            payload_in = glse_pkg::payload_bytes(pixel_count);
            block_in   = 8'd0;
         end
      end
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_user_in  = rsp_user_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit_byte;
         rsp_last_in  = emit_last;
         rsp_user_in  = emit_done;
      end
   end

   always_ff @(posedge clock) begin
      sr_ff       <= sr_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_user_ff <= rsp_user_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= 3'd0;
         data_left_ff <= 3'd0;
         term_ff      <= 1'b0;
         open_ff      <= 1'b0;
         payload_ff   <= '0;
         block_ff     <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         data_left_ff <= data_left_in;
         term_ff      <= term_in;
         open_ff      <= open_in;
         payload_ff   <= payload_in;
         block_ff     <= block_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/gif_literal_lzw_stream_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// gif_literal_lzw_stream_encoder_unit
// Streaming GIF image data encoder with clear code before every pixel.
//
// req_*: one pixel per word (alpha, RGB, upstream index), tlast on the last
//   pixel of a frame. rsp_*: one byte of image data per word, sub-block length
//   bytes included; tlast marks the last byte caused by a pixel, tuser the
//   block terminator. csr_*: exact_palette_mode (index 0), frame_pixel_count
//   (index 1); the user must write them while the block is idle (unenforced).
// A pixel is mapped to its index on acceptance and queued; the packer takes
// the next queued pixel in the cycle that sends the previous pixel's last
// byte. Each pixel yields 2 or 3 data bytes plus any length byte, about 2.25
// bytes on average; the last pixel adds the end code, flush byte and
// terminator. The first byte of a pixel passes the queue, the packer state and
// the output register. The packer's single byte-per-cycle output register
// sets the rate while the receiver is ready.
// Reset clears the queue, the packer and the output valid; the CSRs return
// to quantize mode and a count of one. A stalled receiver holds the output
// word; the queue then fills and req_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module gif_literal_lzw_stream_encoder_unit #(
   parameter int QUEUE_DEPTH = glse_pkg::QueueDepth
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // tdata: pixel_alpha, pixel_red, pixel_green, pixel_blue, exact_index
   input  wire logic [glse_pkg::ReqDataW-1:0]  req_tdata,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic                           req_tlast,   // frame_last
   // tdata: out_byte
   output logic [7:0]                          rsp_tdata,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic                                rsp_tlast,   // run_last
   output logic                                rsp_tuser,   // frame_done
   input  wire logic                           csr_we,
   input  wire logic [glse_pkg::CsrIndexW-1:0] csr_index,
   input  wire logic [glse_pkg::CsrDataW-1:0]  csr_wdata
);

   logic                             mode_ff;
   logic [glse_pkg::PixelCountW-1:0] count_ff;
   logic                             q_full;
   logic                             q_push;
   logic                             q_pop;
   logic                             q_valid;
   glse_pkg::glse_entry_type         q_entry;
   glse_pkg::glse_entry_type         q_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         count_ff <= glse_pkg::PixelCountW'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            glse_pkg::RegExactMode:  mode_ff  <= csr_wdata[0];
            glse_pkg::RegPixelCount: count_ff <= csr_wdata[glse_pkg::PixelCountW-1:0];
            default: begin
            end
         endcase
      end
   end

   glse_front u_front (
      .exact_mode (mode_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (q_entry)
   );

   glse_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .valid      (q_valid),
      .head       (q_head)
   );

   glse_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pixel_count (count_ff),
      .q_valid     (q_valid),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

`default_nettype wire

// ===== src/glse_checker.sv =====
// ----------------------------------------------------------------------------
// glse_checker
// Port-level checks of the encoder output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module glse_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic [7:0] rsp_tdata,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic       rsp_tlast,
   input wire logic       rsp_tuser
);

   a_term_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tlast)
      else $error("terminator word without tlast");

   a_term_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == 8'd0))
      else $error("terminator word not zero");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output valid after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser)))
      else $error("stalled output word changed");

endmodule

bind gif_literal_lzw_stream_encoder_unit glse_checker u_glse_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
